// ----- sv/imh_pkg.sv -----
// Package with the types, constants and status codes of the indexed min-heap.
`timescale 1ns / 1ps
`default_nettype none
package imh_pkg;
    localparam int KEY_BITS   = 10;
    localparam int PRIO_BITS  = 32;
    localparam int SIZE_BITS  = 11;
    localparam int KEY_SPACE  = 1024;
    localparam int CAPACITY   = 1024;
    localparam int SLOT_BITS  = 10;

    typedef logic [1:0]           func_t;
    typedef logic [2:0]           status_t;
    typedef logic [KEY_BITS-1:0]  key_t;
    typedef logic [PRIO_BITS-1:0] prio_t;
    typedef logic [SLOT_BITS-1:0] slot_t;
    typedef logic [SIZE_BITS-1:0] size_t;

    localparam func_t FN_INSERT   = 2'd0;
    localparam func_t FN_DELETE   = 2'd1;
    localparam func_t FN_DECREASE = 2'd2;
    localparam func_t FN_PEEK     = 2'd3;

    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_FULL     = 3'd1;
    localparam status_t ST_EMPTY    = 3'd2;
    localparam status_t ST_KEY      = 3'd3;
    localparam status_t ST_NOTLOWER = 3'd4;

    // Datapath operations requested by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // capture request, read presence and key map
        OP_CHECK,     // evaluate request; read root or target slot
        OP_EVAL,      // take peek result or test decrease priority
        OP_RD_LAST,   // read last slot for delete
        OP_PLACE,     // write new or moved entry into current slot
        OP_RD_A,      // read parent or left child
        OP_RD_B,      // read right child
        OP_CMP,       // compare and decide a swap
        OP_WR_A,      // write current slot of a swap with the other entry
        OP_WR_B       // write other slot of a swap, move down or up
    } op_t;

    typedef struct packed {
        op_t  op;
        logic sift_down;
    } cmd_t;

    typedef struct packed {
        logic    done_now;   // request finishes without sifting
        logic    do_up;      // sift up after place
        logic    need_last;  // delete with remaining entries
        logic    at_top;     // sift-up position is root
        logic    no_child;   // sift-down has no left child
        logic    has_right;  // sift-down has a right child
        logic    swap;       // comparison asks for a swap
        logic    eval_done;  // peek, or decrease to a priority not lower
        logic    init_busy;  // presence memory is being cleared
    } sts_t;
endpackage
`default_nettype wire

// ----- sv/imh_if.sv -----
// Valid/ready channel interfaces for the heap's request and response items.
`timescale 1ns / 1ps
`default_nettype none
interface imh_req_if;
    logic               valid;
    logic               ready;
    imh_pkg::func_t     func;
    imh_pkg::key_t      item_key;
    imh_pkg::prio_t     item_priority;
    modport source (output valid, func, item_key, item_priority, input ready);
    modport sink   (input valid, func, item_key, item_priority, output ready);
endinterface

interface imh_rsp_if;
    logic               valid;
    logic               ready;
    imh_pkg::key_t      result_key;
    imh_pkg::prio_t     result_priority;
    imh_pkg::size_t     heap_size;
    imh_pkg::status_t   status;
    modport source (output valid, result_key, result_priority, heap_size, status,
                    input ready);
    modport sink   (input valid, result_key, result_priority, heap_size, status,
                    output ready);
endinterface
`default_nettype wire

// ----- sv/indexed_min_heap.sv -----
// Indexed binary min-heap with insert, delete-min, decrease-key and peek.
// Usage: one request item on the req channel (func, item_key, item_priority)
// gives one response item on the rsp channel (result_key, result_priority,
// heap_size, status). Requests are taken only while the block is idle.
// A new request is not accepted until the response to the previous one has
// been taken by the receiver. Each sift level reads one or two slots and, on
// a swap, writes two through the single write port of the slot memory.
// After reset the presence bits are cleared by a pass over all 1024 keys,
// during which no request is accepted; the entry count is zero at once. While
// the receiver stalls, the response item is held stable and no new request
// is accepted.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap (
    input  wire logic  clk,
    input  wire logic  rst_n,
    imh_req_if.sink    req,
    imh_rsp_if.source  rsp
);
    imh_pkg::cmd_t cmd;
    imh_pkg::sts_t sts;

    imh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    imh_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .func          (req.func),
        .item_key      (req.item_key),
        .item_priority (req.item_priority),
        .sts           (sts),
        .res_key       (rsp.result_key),
        .res_prio      (rsp.result_priority),
        .res_size      (rsp.heap_size),
        .res_status    (rsp.status)
    );
endmodule
`default_nettype wire

// ----- sv/imh_datapath.sv -----
// Datapath of the heap: slot and key memories, presence bits, comparisons.
`timescale 1ns / 1ps
`default_nettype none
module imh_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire imh_pkg::cmd_t    cmd,
    input  wire imh_pkg::func_t   func,
    input  wire imh_pkg::key_t    item_key,
    input  wire imh_pkg::prio_t   item_priority,
    output imh_pkg::sts_t         sts,
    output imh_pkg::key_t         res_key,
    output imh_pkg::prio_t        res_prio,
    output imh_pkg::size_t        res_size,
    output imh_pkg::status_t      res_status
);
    logic [imh_pkg::KEY_BITS+imh_pkg::PRIO_BITS-1:0] slot_mem [imh_pkg::CAPACITY];
    imh_pkg::slot_t key_pos_mem [imh_pkg::KEY_SPACE];
    logic           present_mem [imh_pkg::KEY_SPACE];

    imh_pkg::func_t   func_reg;
    imh_pkg::key_t    key_reg;
    imh_pkg::prio_t   prio_reg;
    imh_pkg::size_t   count_reg;
    imh_pkg::size_t   clr_reg;
    imh_pkg::slot_t   pos_reg;
    imh_pkg::slot_t   other_reg;
    imh_pkg::key_t    cur_key_reg, oth_key_reg, b_key_reg;
    imh_pkg::prio_t   cur_prio_reg, oth_prio_reg, b_prio_reg;
    logic             present_bit_reg;
    imh_pkg::slot_t   map_reg;
    logic [imh_pkg::KEY_BITS+imh_pkg::PRIO_BITS-1:0] rd_reg;
    imh_pkg::key_t    res_key_reg;
    imh_pkg::prio_t   res_prio_reg;
    imh_pkg::status_t res_status_reg;
    logic             swap_reg;

    logic             rd_en;
    imh_pkg::slot_t   rd_addr;
    logic             wr_en;
    imh_pkg::slot_t   wr_addr;
    logic [imh_pkg::KEY_BITS+imh_pkg::PRIO_BITS-1:0] wr_data;
    logic             map_wr;
    imh_pkg::key_t    map_key;
    imh_pkg::slot_t   map_val;
    logic             pres_wr;
    imh_pkg::key_t    pres_addr;
    logic             pres_val;
    logic             init_busy;
    logic [imh_pkg::SLOT_BITS:0] left_w, right_w;
    imh_pkg::slot_t   parent_w;
    imh_pkg::key_t    rd_key;
    imh_pkg::prio_t   rd_prio;

    assign rd_key    = rd_reg[imh_pkg::KEY_BITS+imh_pkg::PRIO_BITS-1:imh_pkg::PRIO_BITS];
    assign rd_prio   = rd_reg[imh_pkg::PRIO_BITS-1:0];
    assign left_w    = {pos_reg, 1'b1};
    assign right_w   = left_w + 1'b1;
    assign parent_w  = (pos_reg - 1'b1) >> 1;
    assign init_busy = !clr_reg[imh_pkg::KEY_BITS];

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = pos_reg;
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = {cur_key_reg, cur_prio_reg};
        map_wr  = 1'b0;
        map_key = cur_key_reg;
        map_val = pos_reg;
        unique case (cmd.op)
            imh_pkg::OP_CHECK:
            begin
                rd_en   = 1'b1;
                rd_addr = (func_reg == imh_pkg::FN_DECREASE) ? map_reg : '0;
            end
            imh_pkg::OP_RD_LAST:
            begin
                rd_en   = 1'b1;
                rd_addr = count_reg[imh_pkg::SLOT_BITS-1:0];
            end
            imh_pkg::OP_PLACE:
            begin
                wr_en  = 1'b1;
                map_wr = 1'b1;
                if (func_reg == imh_pkg::FN_DELETE)
                begin
                    wr_data = rd_reg;
                    map_key = rd_key;
                end
            end
            imh_pkg::OP_RD_A:
            begin
                rd_en   = 1'b1;
                rd_addr = cmd.sift_down ? left_w[imh_pkg::SLOT_BITS-1:0] : parent_w;
            end
            imh_pkg::OP_RD_B:
            begin
                rd_en   = 1'b1;
                rd_addr = right_w[imh_pkg::SLOT_BITS-1:0];
            end
            imh_pkg::OP_WR_A:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                wr_data = {oth_key_reg, oth_prio_reg};
                map_wr  = 1'b1;
                map_key = oth_key_reg;
                map_val = pos_reg;
            end
            imh_pkg::OP_WR_B:
            begin
                wr_en   = 1'b1;
                wr_addr = other_reg;
                map_wr  = 1'b1;
                map_val = other_reg;
            end
            default:
            begin
            end
        endcase
    end

    // The presence memory is cleared by a pass over all keys after reset.
    always_comb
    begin
        pres_wr   = 1'b0;
        pres_addr = key_reg;
        pres_val  = 1'b0;
        if (init_busy)
        begin
            pres_wr   = 1'b1;
            pres_addr = clr_reg[imh_pkg::KEY_BITS-1:0];
        end
        else if (cmd.op == imh_pkg::OP_CHECK && !sts.done_now
                 && func_reg == imh_pkg::FN_INSERT)
        begin
            pres_wr  = 1'b1;
            pres_val = 1'b1;
        end
        else if (cmd.op == imh_pkg::OP_RD_LAST)
        begin
            pres_wr   = 1'b1;
            pres_addr = rd_key;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_reg <= slot_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (map_wr)
            key_pos_mem[map_key] <= map_val;
        if (cmd.op == imh_pkg::OP_LOAD)
            map_reg <= key_pos_mem[item_key];
    end

    always_ff @(posedge clk)
    begin
        if (pres_wr)
            present_mem[pres_addr] <= pres_val;
        if (cmd.op == imh_pkg::OP_LOAD)
            present_bit_reg <= present_mem[item_key];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            if (init_busy)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.op == imh_pkg::OP_CHECK && sts.done_now == 1'b0)
            begin
                if (func_reg == imh_pkg::FN_INSERT)
                    count_reg <= count_reg + 1'b1;
                else if (func_reg == imh_pkg::FN_DELETE)
                    count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Request evaluation from captured fields.
    always_comb
    begin
        sts = '0;
        unique case (func_reg)
            imh_pkg::FN_INSERT:
                sts.done_now = (count_reg >= imh_pkg::SIZE_BITS'(imh_pkg::CAPACITY))
                               || present_bit_reg;
            imh_pkg::FN_DECREASE:
                sts.done_now = !present_bit_reg;
            default:
                sts.done_now = (count_reg == '0);
        endcase
        sts.need_last = (count_reg != '0);
        sts.do_up     = (func_reg != imh_pkg::FN_DELETE);
        sts.at_top    = (pos_reg == '0);
        sts.no_child  = ({1'b0, left_w} >= {1'b0, count_reg});
        sts.has_right = ({1'b0, right_w} < {1'b0, count_reg});
        sts.swap      = swap_reg;
        sts.eval_done = (func_reg == imh_pkg::FN_PEEK)
                        || (func_reg == imh_pkg::FN_DECREASE && !(prio_reg < rd_prio));
        sts.init_busy = init_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg        <= imh_pkg::FN_PEEK;
            res_status_reg  <= imh_pkg::ST_OK;
            swap_reg        <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                imh_pkg::OP_LOAD:
                begin
                    func_reg        <= func;
                    key_reg         <= item_key;
                    prio_reg        <= item_priority;
                    res_key_reg     <= '0;
                    res_prio_reg    <= '0;
                    res_status_reg  <= imh_pkg::ST_OK;
                end
                imh_pkg::OP_CHECK:
                begin
                    unique case (func_reg)
                        imh_pkg::FN_INSERT:
                        begin
                            if (count_reg >= imh_pkg::SIZE_BITS'(imh_pkg::CAPACITY))
                                res_status_reg <= imh_pkg::ST_FULL;
                            else if (present_bit_reg)
                                res_status_reg <= imh_pkg::ST_KEY;
                            pos_reg      <= count_reg[imh_pkg::SLOT_BITS-1:0];
                            cur_key_reg  <= key_reg;
                            cur_prio_reg <= prio_reg;
                        end
                        imh_pkg::FN_DECREASE:
                        begin
                            if (!present_bit_reg)
                                res_status_reg <= imh_pkg::ST_KEY;
                            pos_reg      <= map_reg;
                            cur_key_reg  <= key_reg;
                            cur_prio_reg <= prio_reg;
                        end
                        default:
                        begin
                            if (count_reg == '0)
                                res_status_reg <= imh_pkg::ST_EMPTY;
                            pos_reg <= '0;
                        end
                    endcase
                end
                imh_pkg::OP_EVAL:
                begin
                    // rd_reg holds the root for a peek or the target slot for a decrease.
                    if (func_reg == imh_pkg::FN_PEEK)
                    begin
                        res_key_reg  <= rd_key;
                        res_prio_reg <= rd_prio;
                    end
                    else if (func_reg == imh_pkg::FN_DECREASE && !(prio_reg < rd_prio))
                        res_status_reg <= imh_pkg::ST_NOTLOWER;
                end
                imh_pkg::OP_RD_LAST:
                begin
                    // rd_reg holds the root here.
                    res_key_reg  <= rd_key;
                    res_prio_reg <= rd_prio;
                end
                imh_pkg::OP_PLACE:
                begin
                    if (func_reg == imh_pkg::FN_DELETE)
                    begin
                        cur_key_reg  <= rd_key;
                        cur_prio_reg <= rd_prio;
                    end
                end
                imh_pkg::OP_RD_A:
                    other_reg <= cmd.sift_down ? left_w[imh_pkg::SLOT_BITS-1:0] : parent_w;
                imh_pkg::OP_RD_B:
                begin
                    b_key_reg  <= rd_key;
                    b_prio_reg <= rd_prio;
                end
                imh_pkg::OP_CMP:
                begin
                    // In a sift-down with two children, b holds the left child and
                    // rd_reg the right child; with one child rd_reg holds the left.
                    if (!cmd.sift_down)
                    begin
                        oth_key_reg  <= rd_key;
                        oth_prio_reg <= rd_prio;
                        swap_reg     <= rd_prio > cur_prio_reg;
                    end
                    else if (sts.has_right && !(b_prio_reg < rd_prio))
                    begin
                        oth_key_reg  <= rd_key;
                        oth_prio_reg <= rd_prio;
                        other_reg    <= right_w[imh_pkg::SLOT_BITS-1:0];
                        swap_reg     <= rd_prio < cur_prio_reg;
                    end
                    else if (sts.has_right)
                    begin
                        oth_key_reg  <= b_key_reg;
                        oth_prio_reg <= b_prio_reg;
                        swap_reg     <= b_prio_reg < cur_prio_reg;
                    end
                    else
                    begin
                        oth_key_reg  <= rd_key;
                        oth_prio_reg <= rd_prio;
                        swap_reg     <= rd_prio < cur_prio_reg;
                    end
                end
                imh_pkg::OP_WR_B:
                    pos_reg <= other_reg;
                default:
                begin
                end
            endcase
            if (cmd.op == imh_pkg::OP_CHECK && func_reg == imh_pkg::FN_PEEK
                && count_reg != '0)
                res_status_reg <= imh_pkg::ST_OK;
        end
    end

    // Peek result and the decrease priority test come from the slot read in CHECK.
    always_comb
    begin
        res_key    = res_key_reg;
        res_prio   = res_prio_reg;
        res_status = res_status_reg;
        res_size   = count_reg;
    end
endmodule
`default_nettype wire

// ----- sv/imh_ctrl.sv -----
// Controller state machine sequencing checks, placement and sifts.
`timescale 1ns / 1ps
`default_nettype none
module imh_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire imh_pkg::sts_t  sts,
    output imh_pkg::cmd_t       cmd
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CHECK = 11'b00000000010,
        S_DEC   = 11'b00000000100,
        S_LAST  = 11'b00000001000,
        S_PLACE = 11'b00000010000,
        S_RDA   = 11'b00000100000,
        S_RDB   = 11'b00001000000,
        S_CMP   = 11'b00010000000,
        S_WRA   = 11'b00100000000,
        S_WRB   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   down_reg, down_next;

    assign in_ready  = (state_reg == S_IDLE) && !sts.init_busy;
    assign out_valid = (state_reg == S_DONE);

    always_comb
    begin
        state_next = state_reg;
        down_next  = down_reg;
        cmd.op        = imh_pkg::OP_NONE;
        cmd.sift_down = down_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                begin
                    cmd.op     = imh_pkg::OP_LOAD;
                    state_next = S_CHECK;
                end
            S_CHECK:
            begin
                cmd.op = imh_pkg::OP_CHECK;
                down_next = !sts.do_up;
                if (sts.done_now)
                    state_next = S_DONE;
                else if (sts.do_up)
                    state_next = S_DEC;
                else
                    state_next = S_LAST;
            end
            S_DEC:
            begin
                cmd.op = imh_pkg::OP_EVAL;
                state_next = sts.eval_done ? S_DONE : S_PLACE;
            end
            S_LAST:
            begin
                cmd.op = imh_pkg::OP_RD_LAST;
                state_next = sts.need_last ? S_PLACE : S_DONE;
            end
            S_PLACE:
            begin
                cmd.op = imh_pkg::OP_PLACE;
                state_next = S_RDA;
            end
            S_RDA:
            begin
                if ((down_reg && sts.no_child) || (!down_reg && sts.at_top))
                    state_next = S_DONE;
                else
                begin
                    cmd.op = imh_pkg::OP_RD_A;
                    state_next = down_reg && sts.has_right ? S_RDB : S_CMP;
                end
            end
            S_RDB:
            begin
                cmd.op = imh_pkg::OP_RD_B;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.op = imh_pkg::OP_CMP;
                state_next = S_WRA;
            end
            S_WRA:
                if (!sts.swap)
                    state_next = S_DONE;
                else
                begin
                    cmd.op = imh_pkg::OP_WR_A;
                    state_next = S_WRB;
                end
            S_WRB:
            begin
                cmd.op = imh_pkg::OP_WR_B;
                state_next = S_RDA;
            end
            S_DONE:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            down_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            down_reg  <= down_next;
        end
    end
endmodule
`default_nettype wire

// ----- sv/imh_checker.sv -----
// Port checker for the indexed min-heap, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module imh_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_ready,
    input wire logic              rsp_valid,
    input wire logic              rsp_ready,
    input wire imh_pkg::key_t     rsp_key,
    input wire imh_pkg::prio_t    rsp_prio,
    input wire imh_pkg::size_t    rsp_size,
    input wire imh_pkg::status_t  rsp_status
);
    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_size <= 11'd1024)
        else $error("heap size beyond capacity");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status <= imh_pkg::ST_NOTLOWER)
        else $error("unknown status");
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status == imh_pkg::ST_EMPTY) |->
        (rsp_key == '0 && rsp_prio == '0 && rsp_size == '0))
        else $error("empty result not cleared");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_key)
        && $stable(rsp_prio) && $stable(rsp_size) && $stable(rsp_status)))
        else $error("response dropped under stall");
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request accepted while a response waits");
endmodule

bind indexed_min_heap imh_checker u_imh_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_key    (rsp.result_key),
    .rsp_prio   (rsp.result_priority),
    .rsp_size   (rsp.heap_size),
    .rsp_status (rsp.status)
);
`default_nettype wire

// ----- test/heap_checker.sv -----
// Checker that predicts the heap's response items and compares them with the block's output.
`timescale 1ns / 1ps
`default_nettype none
module heap_checker (
    input wire logic clk,
    input wire logic rst_n,
    imh_req_if.sink  req,
    imh_rsp_if.sink  rsp,
    output int       fail_count,
    output int       pending
);
    typedef struct packed {
        imh_pkg::key_t    rkey;
        imh_pkg::prio_t   rprio;
        imh_pkg::size_t   size;
        imh_pkg::status_t status;
    } heap_result_t;

    imh_pkg::key_t  slot_key [imh_pkg::CAPACITY];
    imh_pkg::prio_t slot_prio [imh_pkg::CAPACITY];
    int unsigned    key_slot [imh_pkg::KEY_SPACE];
    bit             key_held [imh_pkg::KEY_SPACE];
    int unsigned    count;
    heap_result_t   expected_results[$];

    function automatic void swap_slots(int unsigned i, int unsigned j);
        imh_pkg::key_t  tk;
        imh_pkg::prio_t tp;
        tk = slot_key[i];
        tp = slot_prio[i];
        slot_key[i] = slot_key[j];
        slot_prio[i] = slot_prio[j];
        slot_key[j] = tk;
        slot_prio[j] = tp;
        key_slot[slot_key[i]] = i;
        key_slot[slot_key[j]] = j;
    endfunction

    function automatic void bubble_up(int unsigned pos);
        int unsigned up;
        while (pos > 0)
        begin
            up = (pos - 1) / 2;
            if (!(slot_prio[up] > slot_prio[pos]))
                break;
            swap_slots(up, pos);
            pos = up;
        end
    endfunction

    function automatic void bubble_down(int unsigned pos);
        int unsigned l;
        int unsigned pick;
        forever
        begin
            l = 2 * pos + 1;
            if (l >= count)
                break;
            pick = l;
            if (l + 1 < count && !(slot_prio[l] < slot_prio[l + 1]))
                pick = l + 1;
            if (!(slot_prio[pick] < slot_prio[pos]))
                break;
            swap_slots(pick, pos);
            pos = pick;
        end
    endfunction

    function automatic heap_result_t apply_request(imh_pkg::func_t f, imh_pkg::key_t k,
                                                   imh_pkg::prio_t p);
        heap_result_t r;
        int unsigned  pos;
        r = '0;
        r.status = imh_pkg::ST_OK;
        case (f)
            imh_pkg::FN_INSERT:
                if (count >= imh_pkg::CAPACITY)
                    r.status = imh_pkg::ST_FULL;
                else if (key_held[k])
                    r.status = imh_pkg::ST_KEY;
                else
                begin
                    pos = count;
                    slot_key[pos] = k;
                    slot_prio[pos] = p;
                    key_slot[k] = pos;
                    key_held[k] = 1'b1;
                    count++;
                    bubble_up(pos);
                end
            imh_pkg::FN_DELETE:
                if (count == 0)
                    r.status = imh_pkg::ST_EMPTY;
                else
                begin
                    r.rkey = slot_key[0];
                    r.rprio = slot_prio[0];
                    key_held[r.rkey] = 1'b0;
                    count--;
                    if (count > 0)
                    begin
                        slot_key[0] = slot_key[count];
                        slot_prio[0] = slot_prio[count];
                        key_slot[slot_key[0]] = 0;
                        bubble_down(0);
                    end
                end
            imh_pkg::FN_DECREASE:
                if (!key_held[k] || key_slot[k] >= count)
                    r.status = imh_pkg::ST_KEY;
                else if (!(p < slot_prio[key_slot[k]]))
                    r.status = imh_pkg::ST_NOTLOWER;
                else
                begin
                    slot_prio[key_slot[k]] = p;
                    bubble_up(key_slot[k]);
                end
            default:
                if (count == 0)
                    r.status = imh_pkg::ST_EMPTY;
                else
                begin
                    r.rkey = slot_key[0];
                    r.rprio = slot_prio[0];
                end
        endcase
        r.size = imh_pkg::size_t'(count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        heap_result_t want;
        if (!rst_n)
        begin
            count = 0;
            foreach (key_held[i])
                key_held[i] = 1'b0;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_results.push_back(apply_request(req.func, req.item_key,
                                                         req.item_priority));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("Response item with no request waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.result_key !== want.rkey)
                    begin
                        $error("result_key: expected %0d, actual %0d", want.rkey,
                               rsp.result_key);
                        fail_count++;
                    end
                    if (rsp.result_priority !== want.rprio)
                    begin
                        $error("result_priority: expected %0d, actual %0d", want.rprio,
                               rsp.result_priority);
                        fail_count++;
                    end
                    if (rsp.heap_size !== want.size)
                    begin
                        $error("heap_size: expected %0d, actual %0d", want.size,
                               rsp.heap_size);
                        fail_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status,
                               rsp.status);
                        fail_count++;
                    end
                end
            end
            pending = expected_results.size();
        end
    end
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Top of the heap testbench: clock, reset, request stimulus, response stalls and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   hold_off;
    bit   stimulus_done;

    imh_req_if req ();
    imh_rsp_if rsp ();

    indexed_min_heap dut (.clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source));
    heap_checker checker_i (.clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.sink),
                            .fail_count(fail_count), .pending(pending));

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic send_request(imh_pkg::func_t f, imh_pkg::key_t k, imh_pkg::prio_t p,
                                bit gaps);
        int wait_cycles;
        wait_cycles = gaps ? $urandom_range(0, 16) : 0;
        if (wait_cycles != 0)
        begin
            req.valid <= 1'b0;
            repeat (wait_cycles) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.func <= f;
        req.item_key <= k;
        req.item_priority <= p;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic random_request(bit gaps);
        int             pick;
        imh_pkg::func_t f;
        imh_pkg::key_t  k;
        imh_pkg::prio_t p;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            f = imh_pkg::FN_INSERT;
        else if (pick < 65)
            f = imh_pkg::FN_DELETE;
        else if (pick < 88)
            f = imh_pkg::FN_DECREASE;
        else
            f = imh_pkg::FN_PEEK;
        k = ($urandom_range(0, 3) == 0) ? imh_pkg::key_t'($urandom)
                                        : imh_pkg::key_t'($urandom_range(0, 63));
        case ($urandom_range(0, 3))
            0: p = $urandom;
            1: p = $urandom_range(0, 15);
            2: p = 32'hFFFF_FFF0 | $urandom_range(0, 15);
            default: p = $urandom_range(0, 1000);
        endcase
        send_request(f, k, p, gaps);
    endtask

    // The receiver stalls at random, except for one long hold-off.
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                rsp.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (stall != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
        end
    end

    initial
    begin
        req.valid = 1'b0;
        req.func = imh_pkg::FN_PEEK;
        req.item_key = '0;
        req.item_priority = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(imh_pkg::FN_DELETE, 10'd0, 32'd0, 1'b1);
        send_request(imh_pkg::FN_PEEK, 10'd0, 32'd0, 1'b1);
        send_request(imh_pkg::FN_DECREASE, 10'd5, 32'd1, 1'b1);
        send_request(imh_pkg::FN_INSERT, 10'd1023, 32'hFFFF_FFFF, 1'b1);
        send_request(imh_pkg::FN_INSERT, 10'd0, 32'd0, 1'b1);
        send_request(imh_pkg::FN_INSERT, 10'd0, 32'd7, 1'b1);
        send_request(imh_pkg::FN_INSERT, 10'd512, 32'd0, 1'b1);
        send_request(imh_pkg::FN_INSERT, 10'd341, 32'h8000_0000, 1'b1);
        send_request(imh_pkg::FN_PEEK, 10'd0, 32'd0, 1'b1);
        send_request(imh_pkg::FN_DECREASE, 10'd1023, 32'hFFFF_FFFF, 1'b1);
        send_request(imh_pkg::FN_DECREASE, 10'd341, 32'h8000_0001, 1'b1);
        send_request(imh_pkg::FN_DECREASE, 10'd341, 32'd0, 1'b1);
        send_request(imh_pkg::FN_DECREASE, 10'd1023, 32'h5555_5555, 1'b1);
        send_request(imh_pkg::FN_DECREASE, 10'd682, 32'd3, 1'b1);
        repeat (5) send_request(imh_pkg::FN_DELETE, 10'd0, 32'd0, 1'b1);
        send_request(imh_pkg::FN_PEEK, 10'd0, 32'd0, 1'b1);

        // Offer items without gaps while the receiver holds off.
        hold_off = 1'b1;
        for (int i = 0; i < 60; i++)
            random_request(1'b0);

        for (int i = 0; i < 720; i++)
            random_request($urandom_range(0, 4) != 0);
        req.valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    initial
    begin
        wait (stimulus_done);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
